>>> rtl/lrct_pkg.sv
// shared types and constants for the row cache tag controller
`default_nettype none

package lrct_pkg;

	// fixed field widths of the stream and configuration ports
	localparam int STAMP_W      = 32;
	localparam int ROW_NUMBER_W = 16;
	localparam int MAP_INDEX_W  = 2;
	localparam int WAY_OUT_W    = 3;
	localparam int S_TDATA_W    = 24;
	localparam int M_TDATA_W    = 8;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 4;
	localparam int CFG_REGS     = 4;

	// way count used after reset and for maps without a register
	localparam logic [CFG_DATA_W-1:0] DEFAULT_WAYS = 4'd8;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_WAYS_MAP0 = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WAYS_MAP1 = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WAYS_MAP2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WAYS_MAP3 = 2'd3;

	// running search state handed from one way cell to the next
	typedef struct packed {
		logic               valid;
		logic               hit;
		logic [STAMP_W-1:0] min_stamp;
	} link_t;

	// write-back broadcast to all way cells
	typedef struct packed {
		logic               wr;
		logic               hit;
		logic [STAMP_W-1:0] stamp;
	} upd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

endpackage

`default_nettype wire

>>> rtl/lrct_cell.sv
// one cache way: tag, valid and stamp of every map, plus one step of the search chain
`default_nettype none

module lrct_cell #(
	parameter int IDX      = 0,
	parameter int MAPS     = 4,
	parameter int WAYS     = 8,
	parameter int ROW_BITS = 16,
	localparam int MAP_W   = (MAPS > 1) ? $clog2(MAPS) : 1,
	localparam int WIDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1,
	localparam int CNT_W   = $clog2(WAYS + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [MAP_W-1:0]     sel_map,
	input  wire logic [ROW_BITS-1:0]  tag,
	input  wire logic [CNT_W-1:0]     way_count,
	input  wire lrct_pkg::link_t      link_in,
	input  wire logic [WIDX_W-1:0]    hit_way_in,
	input  wire logic [WIDX_W-1:0]    min_way_in,
	output lrct_pkg::link_t           link_out,
	output logic [WIDX_W-1:0]         hit_way_out,
	output logic [WIDX_W-1:0]         min_way_out,
	input  wire lrct_pkg::upd_t       upd,
	input  wire logic [WIDX_W-1:0]    upd_way
);
	import lrct_pkg::*;

	localparam logic [WIDX_W-1:0] MY_WAY = WIDX_W'(IDX);

	logic [ROW_BITS-1:0] tag_q   [MAPS];
	logic [STAMP_W-1:0]  stamp_q [MAPS];
	logic [MAPS-1:0]     valid_q;

	logic [ROW_BITS-1:0] cur_tag;
	logic [STAMP_W-1:0]  cur_stamp;
	logic                cur_valid;
	logic                active;
	logic                my_write;

	link_t               link_d;
	logic [WIDX_W-1:0]   hit_way_d;
	logic [WIDX_W-1:0]   min_way_d;

	link_t               link_q;
	logic [WIDX_W-1:0]   hit_way_q;
	logic [WIDX_W-1:0]   min_way_q;

	// entry of the requested map
	assign cur_tag   = tag_q[sel_map];
	assign cur_stamp = stamp_q[sel_map];
	assign cur_valid = valid_q[sel_map];
	assign active    = CNT_W'(IDX) < way_count;
	assign my_write  = upd.wr && (upd_way == MY_WAY);

	// search step: first matching way wins, last smallest stamp is the victim
	always_comb begin
		link_d    = link_in;
		hit_way_d = hit_way_in;
		min_way_d = min_way_in;
		if (link_in.valid && active) begin
			if (!link_in.hit && cur_valid && (cur_tag == tag)) begin
				link_d.hit = 1'b1;
				hit_way_d  = MY_WAY;
			end
			if ((IDX == 0) || (cur_stamp <= link_in.min_stamp)) begin
				link_d.min_stamp = cur_stamp;
				min_way_d        = MY_WAY;
			end
		end
	end

	// chain register toward the next way
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q    <= '0;
			hit_way_q <= '0;
			min_way_q <= '0;
		end else begin
			link_q    <= link_d;
			hit_way_q <= hit_way_d;
			min_way_q <= min_way_d;
		end
	end

	assign link_out    = link_q;
	assign hit_way_out = hit_way_q;
	assign min_way_out = min_way_q;

	// stamps and valid bits start cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAPS; i++) begin
				stamp_q[i] <= '0;
			end
			valid_q <= '0;
		end else if (my_write) begin
			stamp_q[sel_map] <= upd.stamp;
			if (!upd.hit) begin
				valid_q[sel_map] <= 1'b1;
			end
		end
	end

	// tags are only read behind their valid bit
	always_ff @(posedge clk) begin
		if (my_write && !upd.hit) begin
			tag_q[sel_map] <= tag;
		end
	end

endmodule

`default_nettype wire

>>> rtl/lru_row_cache_tags.sv
// top level of the row cache tag controller: request control, way count registers, way chain
`default_nettype none

// Tag and LRU replacement control for a per-map fully associative row cache.
// Each request item (map, row) gets one result item: hit with the way that
// holds the row, or miss with the way to refill, chosen as the way in use with
// the oldest stamp (highest way on ties). Every request advances a 32-bit
// access counter that stamps the way used; stamps wrap without handling.
// The ways form a chain of cells, one per way, and a request walks down that
// chain one cell per cycle; its result is registered at the chain end, and a
// new item is taken the cycle after that result is written to the output
// register, so no new item is taken before the last one is through; a result
// held by the receiver delays that write. The output register holds a result
// while the next item is accepted. Way counts are to be set by the user
// through the cfg port while no request is in flight; the block does not
// enforce this. A write takes effect at once.
module lru_row_cache_tags #(
	parameter int MAPS     = 4,
	parameter int WAYS     = 8,
	parameter int ROW_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// request item
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [lrct_pkg::S_TDATA_W-1:0]    s_tdata,   // map_index[1:0], row_number[17:2]
	// result item
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [lrct_pkg::M_TDATA_W-1:0]         m_tdata,   // way[2:0]
	output logic                                   m_tuser,   // hit[0]
	// configuration writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lrct_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [lrct_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import lrct_pkg::*;

	localparam int MAP_W  = (MAPS > 1) ? $clog2(MAPS) : 1;
	localparam int WIDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CNT_W  = $clog2(WAYS + 1);

	state_t state_q, state_d;

	logic [CFG_DATA_W-1:0] ways_q [CFG_REGS];
	logic [STAMP_W-1:0]    count_q;

	logic [MAP_W-1:0]      map_q;
	logic [ROW_BITS-1:0]   tag_q;
	logic [CNT_W-1:0]      n_q;
	logic                  start_q;

	logic                  res_hit_q;
	logic [WIDX_W-1:0]     res_way_q;
	logic                  out_valid_q;
	logic                  out_hit_q;
	logic [WIDX_W-1:0]     out_way_q;

	logic                  accept;
	logic                  take_result;
	logic                  commit;

	logic [MAP_INDEX_W-1:0]  map_in;
	logic [ROW_NUMBER_W-1:0] row_in;
	logic [3:0]              map_ext;
	logic [3:0]              map_red;
	logic [CFG_DATA_W-1:0]   raw_ways;
	logic [7:0]              raw8;
	logic [7:0]              n_next;

	link_t             link    [WAYS+1];
	logic [WIDX_W-1:0] hit_way [WAYS+1];
	logic [WIDX_W-1:0] min_way [WAYS+1];
	upd_t              upd;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_REGS; i++) begin
				ways_q[i] <= DEFAULT_WAYS;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WAYS_MAP0: ways_q[0] <= cfg_data;
				REG_WAYS_MAP1: ways_q[1] <= cfg_data;
				REG_WAYS_MAP2: ways_q[2] <= cfg_data;
				REG_WAYS_MAP3: ways_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// request decode: fold the map into range, clamp its way count
	assign map_in  = s_tdata[MAP_INDEX_W-1:0];
	assign row_in  = s_tdata[MAP_INDEX_W +: ROW_NUMBER_W];
	assign map_ext = 4'(map_in);

	always_comb begin
		if (MAPS == 1) begin
			map_red = '0;
		end else if (map_ext >= 4'(MAPS)) begin
			map_red = map_ext - 4'(MAPS);
		end else begin
			map_red = map_ext;
		end
		if (map_red < 4'(CFG_REGS)) begin
			raw_ways = ways_q[map_red[CFG_INDEX_W-1:0]];
		end else begin
			raw_ways = DEFAULT_WAYS;
		end
		raw8 = 8'(raw_ways);
		priority if (raw8 == 8'd0) begin
			n_next = 8'd1;
		end else if (raw8 > 8'(WAYS)) begin
			n_next = 8'(WAYS);
		end else begin
			n_next = raw8;
		end
	end

	// request sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		accept      = 1'b0;
		take_result = 1'b0;
		commit      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					accept  = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (link[WAYS].valid) begin
					take_result = 1'b1;
					state_d     = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (!out_valid_q || m_tready) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// access counter and chain start pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			start_q <= 1'b0;
		end else begin
			start_q <= accept;
			if (accept) begin
				count_q <= count_q + STAMP_W'(1);
			end
		end
	end

	// request held for the whole walk
	always_ff @(posedge clk) begin
		if (accept) begin
			map_q <= MAP_W'(map_red);
			tag_q <= ROW_BITS'(row_in);
			n_q   <= CNT_W'(n_next);
		end
		if (take_result) begin
			res_hit_q <= link[WAYS].hit;
			res_way_q <= link[WAYS].hit ? hit_way[WAYS] : min_way[WAYS];
		end
	end

	// chain entry
	assign link[0].valid     = start_q;
	assign link[0].hit       = 1'b0;
	assign link[0].min_stamp = '0;
	assign hit_way[0]        = '0;
	assign min_way[0]        = '0;

	// write-back to the chosen way
	assign upd.wr    = commit;
	assign upd.hit   = res_hit_q;
	assign upd.stamp = count_q;

	// one cell per way
	for (genvar g = 0; g < WAYS; g++) begin : g_way
		lrct_cell #(
			.IDX      (g),
			.MAPS     (MAPS),
			.WAYS     (WAYS),
			.ROW_BITS (ROW_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.sel_map     (map_q),
			.tag         (tag_q),
			.way_count   (n_q),
			.link_in     (link[g]),
			.hit_way_in  (hit_way[g]),
			.min_way_in  (min_way[g]),
			.link_out    (link[g+1]),
			.hit_way_out (hit_way[g+1]),
			.min_way_out (min_way[g+1]),
			.upd         (upd),
			.upd_way     (res_way_q)
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_hit_q <= res_hit_q;
			out_way_q <= res_way_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_hit_q;
	assign m_tdata  = M_TDATA_W'(WAY_OUT_W'(out_way_q));

endmodule

`default_nettype wire
